### hw/rtl/npru_pkg.sv
// ----------------------------------------------------------------------------
// npru_pkg: shared types and constants of the nearest-point demapper
// Table geometry, coordinate and distance widths, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package npru_pkg;

    // Table geometry and coordinate format
    localparam int MAX_POINTS  = 256;
    localparam int COORD_WIDTH = 16;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);

    // Request fields with widths fixed by the interface
    localparam int PIDX_W      = 8;
    localparam int SYM_W       = 8;
    localparam int PCOUNT_W    = 9;

    // Distance datapath
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int SQ_W        = 2 * COORD_WIDTH + 1;
    localparam int DIST_W      = 33;
    localparam int CMP_W       = (SQ_W + 1 > DIST_W) ? SQ_W + 1 : DIST_W;

    // APB register map
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_W   = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = '0;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DEMAP = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic [SQ_W-1:0]               t_square;
    typedef logic [DIST_W-1:0]             t_dist;
    typedef logic [ADDR_W-1:0]             t_addr;
    typedef logic [CNT_W-1:0]              t_count;

    localparam t_dist DIST_ONES = '1;

endpackage

`default_nettype wire

### hw/rtl/npru_if.sv
// ----------------------------------------------------------------------------
// npru_if: request and result channels of the nearest-point demapper
// Valid/ready channels carrying one request or one result each.
// ----------------------------------------------------------------------------
`default_nettype none

interface npru_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [npru_pkg::PIDX_W-1:0]    point_index;
    npru_pkg::t_coord               point_i;
    npru_pkg::t_coord               point_q;
    npru_pkg::t_coord               rx_i;
    npru_pkg::t_coord               rx_q;

    modport source (
        output valid, command, point_index, point_i, point_q, rx_i, rx_q,
        input  ready
    );
    modport sink (
        input  valid, command, point_index, point_i, point_q, rx_i, rx_q,
        output ready
    );
endinterface

interface npru_out_if;
    logic                           valid;
    logic                           ready;
    logic [npru_pkg::SYM_W-1:0]     symbol;
    npru_pkg::t_dist                best_sqd;
    npru_pkg::t_dist                second_sqd;

    modport source (
        output valid, symbol, best_sqd, second_sqd,
        input  ready
    );
    modport sink (
        input  valid, symbol, best_sqd, second_sqd,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/npru_ram.sv
// ----------------------------------------------------------------------------
// npru_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/nearest_point_with_runner_up_top.sv
// ----------------------------------------------------------------------------
// nearest_point_with_runner_up_top: hard-decision demapper with runner-up
// Stores a constellation of I/Q points and, for each sample, returns the
// nearest point index, the smallest and the second smallest squared distance.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Carries
//  i_in      request    valid / ready    command, point_index, point_i/q,
//                                        rx_i/q
//  o_out     result     valid / ready    symbol, best_sqd,
//                                        second_sqd
//  APB       config     psel / penable   point_count at byte address 0
//
//  A load request writes one table entry.
//  A demap request has one distance unit walk the table at one entry per cycle
//  through a five-stage pipeline (table read, difference, square, sum,
//  compare), then loads the result into the output register once that
//  register is free.
//  Reset (i_rst_n low, synchronous) clears the sequencer, the output valid and
//  point_count; the table has no reset and must be loaded before use.
//  i_in.ready is high only while the sequencer is idle; a result waiting on
//  o_out does not block further requests until the next one is due out.
//
`default_nettype none

module nearest_point_with_runner_up_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    npru_in_if.sink                            i_in,
    npru_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [npru_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [npru_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [npru_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);

    // Sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int RAM_W = 2 * npru_pkg::COORD_WIDTH;

    // ---------------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------------
    logic [npru_pkg::PCOUNT_W-1:0]  r_point_count;
    logic [npru_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                           w_cfg_wr;

    assign w_reg_idx = paddr[npru_pkg::PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite
                       && (w_reg_idx == npru_pkg::REG_POINT_COUNT);
    assign pready    = 1'b1;

    always_comb begin
        prdata = '0;
        if (w_reg_idx == npru_pkg::REG_POINT_COUNT) begin
            prdata = npru_pkg::APB_DATA_W'(r_point_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (w_cfg_wr) begin
            r_point_count <= pwdata[npru_pkg::PCOUNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------------
    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic               w_in_acc;
    logic               w_load;
    logic               w_demap;
    npru_pkg::t_count   w_count_clamp;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    // Drop loads aimed beyond the table
    assign w_load     = w_in_acc && (i_in.command == npru_pkg::CMD_LOAD)
                        && (int'(i_in.point_index) < npru_pkg::MAX_POINTS);
    assign w_demap    = w_in_acc && (i_in.command == npru_pkg::CMD_DEMAP);

    // Clamp the scan length to the table depth
    assign w_count_clamp = (int'(r_point_count) > npru_pkg::MAX_POINTS)
                           ? npru_pkg::CNT_W'(npru_pkg::MAX_POINTS)
                           : npru_pkg::CNT_W'(r_point_count);

    // ---------------------------------------------------------------------
    // Constellation table: I in the upper half, Q in the lower half
    // ---------------------------------------------------------------------
    logic [RAM_W-1:0]   w_rd_data;
    npru_pkg::t_count   r_issue;
    npru_pkg::t_count   r_n;
    logic               w_issue;

    assign w_issue = (r_state == ST_SCAN) && (r_issue < r_n);

    npru_ram #(
        .WIDTH (RAM_W),
        .DEPTH (npru_pkg::MAX_POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (npru_pkg::ADDR_W'(i_in.point_index)),
        .i_wr_data ({i_in.point_i, i_in.point_q}),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_issue[npru_pkg::ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // ---------------------------------------------------------------------
    // Distance pipeline
    // ---------------------------------------------------------------------
    npru_pkg::t_coord   r_rx_i;
    npru_pkg::t_coord   r_rx_q;
    npru_pkg::t_coord   w_tab_i;
    npru_pkg::t_coord   w_tab_q;

    logic               r_v1, r_v2, r_v3, r_v4;
    npru_pkg::t_addr    r_idx1, r_idx2, r_idx3, r_idx4;
    npru_pkg::t_diff    r_di, r_dq;
    npru_pkg::t_square  r_sqi, r_sqq;
    npru_pkg::t_dist    r_dist;

    logic signed [2*npru_pkg::DIFF_W-1:0] w_prod_i;
    logic signed [2*npru_pkg::DIFF_W-1:0] w_prod_q;
    logic [npru_pkg::CMP_W-1:0]           w_sum;
    npru_pkg::t_dist                      w_dist_sat;

    assign w_tab_i  = w_rd_data[RAM_W-1:npru_pkg::COORD_WIDTH];
    assign w_tab_q  = w_rd_data[npru_pkg::COORD_WIDTH-1:0];
    assign w_prod_i = r_di * r_di;
    assign w_prod_q = r_dq * r_dq;
    assign w_sum    = npru_pkg::CMP_W'(r_sqi) + npru_pkg::CMP_W'(r_sqq);
    // Keep all-ones reserved for "no point"
    assign w_dist_sat = (w_sum >= npru_pkg::CMP_W'(npru_pkg::DIST_ONES))
                        ? npru_pkg::DIST_ONES - npru_pkg::DIST_W'(1)
                        : npru_pkg::DIST_W'(w_sum);

    always_ff @(posedge i_clk) begin
        if (w_demap) begin
            r_rx_i <= i_in.rx_i;
            r_rx_q <= i_in.rx_q;
        end
        // Table data arrives in the cycle after the read
        r_idx1 <= r_issue[npru_pkg::ADDR_W-1:0];
        // Difference
        r_di   <= npru_pkg::DIFF_W'(r_rx_i) - npru_pkg::DIFF_W'(w_tab_i);
        r_dq   <= npru_pkg::DIFF_W'(r_rx_q) - npru_pkg::DIFF_W'(w_tab_q);
        r_idx2 <= r_idx1;
        // Square
        r_sqi  <= npru_pkg::SQ_W'(w_prod_i);
        r_sqq  <= npru_pkg::SQ_W'(w_prod_q);
        r_idx3 <= r_idx2;
        // Sum and saturate
        r_dist <= w_dist_sat;
        r_idx4 <= r_idx3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // ---------------------------------------------------------------------
    // Best / runner-up tracking: strict less-than keeps the first minimum
    // ---------------------------------------------------------------------
    npru_pkg::t_dist    r_best, r_second;
    npru_pkg::t_addr    r_best_idx;

    always_ff @(posedge i_clk) begin
        if (w_demap) begin
            r_best     <= npru_pkg::DIST_ONES;
            r_second   <= npru_pkg::DIST_ONES;
            r_best_idx <= '0;
        end else if (r_v4) begin
            if (r_dist < r_best) begin
                r_second   <= r_best;
                r_best     <= r_dist;
                r_best_idx <= r_idx4;
            end else if (r_dist < r_second) begin
                r_second   <= r_dist;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer and scan counter
    // ---------------------------------------------------------------------
    logic w_pipe_empty;
    logic w_out_free;

    assign w_pipe_empty = !w_issue && !r_v1 && !r_v2 && !r_v3 && !r_v4;
    assign w_out_free   = !o_out.valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_demap) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_pipe_empty) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register can take the result
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_issue <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            if (w_demap) begin
                r_issue <= '0;
                r_n     <= w_count_clamp;
            end else if (w_issue) begin
                r_issue <= r_issue + npru_pkg::CNT_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    logic                       r_out_valid;
    logic [npru_pkg::SYM_W-1:0] r_out_symbol;
    npru_pkg::t_dist            r_out_nearest;
    npru_pkg::t_dist            r_out_next;
    logic                       w_emit;

    assign w_emit = (r_state == ST_EMIT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_symbol  <= npru_pkg::SYM_W'(r_best_idx);
            r_out_nearest <= r_best;
            r_out_next    <= r_second;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.symbol     = r_out_symbol;
    assign o_out.best_sqd   = r_out_nearest;
    assign o_out.second_sqd = r_out_next;

endmodule

`default_nettype wire
